// ===== hw/rtl/lcu_pkg.sv =====
// Package for the Latin-1 / Windows-1252 to UTF-8 transcoder.
// Holds the queue entry type, register indexes and the Windows-1252 table.
// No dependencies.
`default_nettype none

package lcu_pkg;

  // Register indexes of the configuration port (byte address = 4 * index).
  localparam int unsigned RegSourceEncoding = 0;
  localparam int unsigned CfgAddrW          = 3;
  localparam int unsigned CfgDataW          = 32;

  // Source encoding codes.
  localparam logic EncLatin1 = 1'b0;
  localparam logic EncCp1252 = 1'b1;

  // Default depth of the queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [15:0] ReplacementCp = 16'hFFFD;

  // One classified transaction: up to three UTF-8 bytes, lead byte in slot 0.
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
  } lcu_entry_t;

  // Windows-1252 code points for source bytes 0x80..0x9F.
  function automatic logic [15:0] cp1252_lookup(input logic [4:0] idx);
    logic [15:0] cp;
    unique case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = ReplacementCp;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = ReplacementCp;
      5'd14: cp = 16'h017D;
      5'd15: cp = ReplacementCp;
      5'd16: cp = ReplacementCp;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = ReplacementCp;
      5'd30: cp = 16'h017E;
      5'd31: cp = 16'h0178;
      default: cp = ReplacementCp;
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/latin1_cp1252_to_utf8_core.sv =====
// Top level of the Latin-1 / Windows-1252 to UTF-8 transcoder.
// Instantiates lcu_front, lcu_queue and lcu_back; depends on lcu_pkg.
//
// Usage: each input transaction on the in_ channel (valid/ready) carries one
// source byte. The block answers with the byte's UTF-8 encoding on the out_
// channel, one byte per transaction, lead byte first, with out_last_byte
// high on the final byte of the sequence. ASCII gives one byte, 0xA0..0xFF
// give two, and 0x80..0x9F give two or three depending on source_encoding
// (register 0 on the cfg_ APB port: 0 = Latin-1, which maps them to U+FFFD,
// 1 = Windows-1252). A zero byte is accepted and produces no output.
// Each accepted entry is registered in the queue; its bytes then pass one
// at a time, lead byte first, through the output register. Throughput: the
// single output byte lane delivers one byte per cycle while the receiver is
// ready; an item is one, two or three bytes long. The front end keeps
// accepting while the queue has room, so a stalled receiver only holds the
// output register and the queue; nothing is lost or repeated. Synchronous
// reset clears the queue, the output stage and source_encoding to Latin-1.
`default_nettype none

module latin1_cp1252_to_utf8_core
  import lcu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_last_byte,
  // Configuration port
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0]      cfg_prdata,
  output logic                     cfg_pready
);

  localparam logic RegSelSrcEnc = RegSourceEncoding[0];

  logic       source_encoding_r, source_encoding_nxt;
  logic       cfg_write;
  logic       q_full, q_push, q_pop, q_not_empty;
  lcu_entry_t q_entry, q_head;

  // The register file: one bit at byte address 0. Address bit 2 selects the
  // register index; the byte-lane bits below it are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    source_encoding_nxt = source_encoding_r;
    if (cfg_write && (cfg_paddr[2] == RegSelSrcEnc)) begin
      source_encoding_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_encoding_r <= EncLatin1;
    end else begin
      source_encoding_r <= source_encoding_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == RegSelSrcEnc) begin
      cfg_prdata[0] = source_encoding_r;
    end
  end

  // Front end: classification and encoding straight into the queue.
  lcu_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .source_encoding (source_encoding_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  // The queue decouples the front end from the byte serialiser.
  lcu_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Back end: one output byte per cycle while out_ready, through a registered stage.
  lcu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lcu_front.sv =====
// Front end of the transcoder: accepts source bytes and encodes them.
// Produces one queue entry per non-zero byte. Depends on lcu_pkg.
`default_nettype none

module lcu_front
  import lcu_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       source_encoding,
  input  wire logic       q_full,
  output logic            q_push,
  output lcu_entry_t      q_entry
);

  logic [15:0] cp;

  // A zero byte is taken but produces nothing.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && (in_byte != 8'h00);

  always_comb begin
    if (!in_byte[7]) begin
      cp = {8'h00, in_byte};
    end else if (in_byte[6:5] == 2'b00) begin
      cp = (source_encoding == EncCp1252) ? cp1252_lookup(in_byte[4:0]) : ReplacementCp;
    end else begin
      cp = {8'h00, in_byte};
    end
  end

  always_comb begin
    q_entry = '0;
    if (cp[15:7] == 9'd0) begin
      q_entry.nbytes   = 2'd1;
      q_entry.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp[15:11] == 5'd0) begin
      q_entry.nbytes   = 2'd2;
      q_entry.bytes[0] = {3'b110, cp[10:6]};
      q_entry.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      q_entry.nbytes   = 2'd3;
      q_entry.bytes[0] = {4'b1110, cp[15:12]};
      q_entry.bytes[1] = {2'b10, cp[11:6]};
      q_entry.bytes[2] = {2'b10, cp[5:0]};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcu_queue.sv =====
// Short queue of encoded entries between the front and back ends. Depends
// on lcu_pkg. Register based, one push while not full and one pop per cycle.
`default_nettype none

module lcu_queue
  import lcu_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire lcu_entry_t push_entry,
  input  wire logic       pop,
  output logic            full,
  output logic            not_empty,
  output lcu_entry_t      head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  lcu_entry_t      mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == FullCnt);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcu_back.sv =====
// Back end of the transcoder: serialises queue entries into UTF-8 bytes.
// One byte per cycle while out_ready, through a registered output stage. Depends on lcu_pkg.
`default_nettype none

module lcu_back
  import lcu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_not_empty,
  input  wire lcu_entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_byte
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load, is_last;

  assign load    = q_not_empty && (!valid_r || out_ready);
  assign is_last = (idx_r == (q_head.nbytes - 2'd1));
  assign q_pop   = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= q_head.bytes[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;

endmodule

`default_nettype wire

// ===== bench/tb_latin1_cp1252_to_utf8_core.sv =====
// Self-checking testbench for latin1_cp1252_to_utf8_core: random and directed
// source bytes in both source encodings, checked against a UTF-8 scoreboard.
// Depends on lcu_pkg and the transcoder RTL only.
`timescale 1ns / 1ps

module tb_latin1_cp1252_to_utf8_core;
  import lcu_pkg::*;

  // Settling time after the last expected byte, in clock cycles.
  localparam int SETTLE_CYCLES = 4;
  // Generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_ITEMS   = 26;

  localparam logic [CfgAddrW-1:0] ENC_ADDR   = CfgAddrW'(RegSourceEncoding * 4);
  // Address of a register slot that does not exist; writes there must be ignored.
  localparam logic [CfgAddrW-1:0] SPARE_ADDR = CfgAddrW'((RegSourceEncoding + 1) * 4);

  // Directed bytes for the Latin-1 setting: both ends of ASCII, the end-of-string
  // zero, the 0x80..0x9F band (replacement character) and the 0xA0..0xFF band.
  localparam logic [7:0] LATIN1_CASES [10] = '{
    8'h01, 8'h41, 8'h7F, 8'h00, 8'h80, 8'h8D, 8'h9F, 8'hA0, 8'hE9, 8'hFF
  };
  // Directed bytes for the Windows-1252 setting: every undefined entry, the
  // euro sign, entries giving two- and three-byte sequences, and band edges.
  localparam logic [7:0] CP1252_CASES [14] = '{
    8'h80, 8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D, 8'h82, 8'h83,
    8'h88, 8'h99, 8'h9F, 8'h00, 8'h7E, 8'hA9
  };

  // One UTF-8 output byte as the block should present it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_unit_t;

  // Keeps the current source encoding, works out the UTF-8 bytes of every
  // accepted source byte and checks the bytes that come out in order.
  class utf8_tracker;
    logic          encoding;
    int            fail_count;
    utf8_unit_t    pending_units[$];
    logic [15:0]   win1252_cp [32];

    function new();
      encoding   = EncLatin1;
      fail_count = 0;
      win1252_cp = '{
        16'h20AC, ReplacementCp, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, ReplacementCp, 16'h017D,
        ReplacementCp, ReplacementCp, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022,
        16'h2013, 16'h2014, 16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153,
        ReplacementCp, 16'h017E, 16'h0178
      };
    endfunction

    function int pending();
      return pending_units.size();
    endfunction

    // A source byte was accepted: queue its UTF-8 encoding.
    function void note_source_byte(logic [7:0] src);
      logic [15:0] cp;
      if (src == 8'h00) return;
      if (src < 8'h80)
        cp = {8'h00, src};
      else if (src < 8'hA0)
        cp = (encoding == EncCp1252) ? win1252_cp[src[4:0]] : ReplacementCp;
      else
        cp = {8'h00, src};
      if (cp < 16'h0080) begin
        pending_units.push_back('{cp[7:0], 1'b1});
      end else if (cp < 16'h0800) begin
        pending_units.push_back('{{3'b110, cp[10:6]}, 1'b0});
        pending_units.push_back('{{2'b10, cp[5:0]}, 1'b1});
      end else begin
        pending_units.push_back('{{4'b1110, cp[15:12]}, 1'b0});
        pending_units.push_back('{{2'b10, cp[11:6]}, 1'b0});
        pending_units.push_back('{{2'b10, cp[5:0]}, 1'b1});
      end
    endfunction

    // An output byte was accepted: compare it with the oldest expectation.
    function void check_utf8_byte(logic [7:0] data, logic last);
      utf8_unit_t want;
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected output byte %02h last %0b", $time, data, last);
        fail_count++;
        return;
      end
      want = pending_units.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        fail_count++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last_byte expected %0b actual %0b", $time, want.last, last);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_byte;
  logic                out_last_byte;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  // Random gaps on both channels are only inserted while this is set.
  bit                  gaps_enabled = 1'b1;
  int                  cycle_count = 0;
  utf8_tracker         tracker = new();

  latin1_cp1252_to_utf8_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake must not leave the run spinning for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d bytes outstanding", $time, tracker.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Monitors. All stimulus is driven with nonblocking assignments, so the
  // values read here are those that were present just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ENC_ADDR) begin
        tracker.encoding = cfg_pwdata[0];
      end
      if (in_valid && in_ready) begin
        tracker.note_source_byte(in_byte);
      end
      if (out_valid && out_ready) begin
        tracker.check_utf8_byte(out_byte, out_last_byte);
      end
    end
  end

  // Receiver: mostly ready, with random stall bursts while gaps are enabled.
  initial begin
    forever begin
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offers one source byte and returns once the transaction has been taken.
  // Valid is left high so that back-to-back bytes follow without valid dropping.
  task automatic send_byte(input logic [7:0] src);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= src;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every expected byte has come out. A zero
  // byte gives no output, so a settling wait after that lets it clear the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: a setup phase, then the access phase until pready,
  // followed by an idle phase on the bus.
  task automatic cfg_access(input bit wr, input logic [CfgAddrW-1:0] addr,
                            input logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the source encoding with random upper bits, which the block must
  // discard, and reads the register back.
  task automatic program_encoding(input logic enc);
    logic [CfgDataW-1:0] word;
    logic [CfgDataW-1:0] readback;
    word    = CfgDataW'($urandom());
    word[0] = enc;
    cfg_access(1'b1, ENC_ADDR, word, readback);
    cfg_access(1'b0, ENC_ADDR, '0, readback);
    if (readback !== CfgDataW'(enc)) begin
      $display("%0t: source_encoding read expected %08h actual %08h",
               $time, CfgDataW'(enc), readback);
      tracker.fail_count++;
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] readback;
    logic                enc;
    logic [7:0]          src;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The register must come out of reset in Latin-1 mode.
    cfg_access(1'b0, ENC_ADDR, '0, readback);
    if (readback !== CfgDataW'(EncLatin1)) begin
      $display("%0t: reset source_encoding expected %08h actual %08h",
               $time, CfgDataW'(EncLatin1), readback);
      tracker.fail_count++;
    end

    // Directed part, first in the reset encoding.
    foreach (LATIN1_CASES[i]) send_byte(LATIN1_CASES[i]);
    drain();
    program_encoding(EncCp1252);
    // A write to a slot with no register behind it must change nothing.
    cfg_access(1'b1, SPARE_ADDR, CfgDataW'($urandom()), readback);
    foreach (CP1252_CASES[i]) send_byte(CP1252_CASES[i]);
    drain();

    // Random part: each phase runs under one encoding, set while idle. The
    // first two phases force both settings; later ones choose at random.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == 0)
        enc = EncLatin1;
      else if (ph == 1)
        enc = EncCp1252;
      else
        enc = $urandom_range(0, 1) ? EncCp1252 : EncLatin1;
      program_encoding(enc);
      // One phase in the middle and the final one run without any gaps.
      gaps_enabled = (ph != 3) && (ph != PHASE_COUNT - 1);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Weight towards the 0x80..0x9F band, where the encodings differ.
        case ($urandom_range(0, 7))
          0, 1:    src = 8'($urandom_range(8'h80, 8'h9F));
          2, 3:    src = 8'($urandom_range(8'hA0, 8'hFF));
          4:       src = 8'($urandom_range(8'h01, 8'h7F));
          5:       src = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          default: src = 8'($urandom_range(0, 255));
        endcase
        send_byte(src);
        // Hold the sender off until the output side has caught up once.
        if (ph == 2 && n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== latin1_cp1252_to_utf8_core.f =====
hw/rtl/lcu_pkg.sv
hw/rtl/lcu_front.sv
hw/rtl/lcu_queue.sv
hw/rtl/lcu_back.sv
hw/rtl/latin1_cp1252_to_utf8_core.sv
bench/tb_latin1_cp1252_to_utf8_core.sv
